/* rtl/nth_pkg.sv */
// ----------------------------------------------------------------------------
// nth_pkg: shared types and constants for the note tracker
// Sequencer states, fixed-point constants of the pitch math and defaults
// for the top-level parameters.
// ----------------------------------------------------------------------------
package nth_pkg;

  // Default fraction bits of the base-2 logarithm.
  localparam int LOG_FRAC_BITS_DEF = 12;

  // log2(440 * 256) in Q32.
  localparam logic [63:0] REF_LOG2_Q32 = 64'd72075391152;

  // Reset value of the hysteresis register, whole cents.
  localparam logic [6:0] HYST_RESET = 7'd50;

  // Pitch math in hundredths of a cent.
  localparam int CENTS_PER_OCT = 120000;
  localparam int PITCH_A4      = 690000;
  localparam int NOTE_STEP     = 10000;
  localparam int HALF_STEP     = 5000;
  localparam int HYST_SCALE    = 100;
  localparam int OFF_LIMIT     = 20000;

  // Nearest-note division: floor(x / 10000) = (x * RECIP_K) >> RECIP_SHIFT
  // for 0 <= x < NOTE_SAT_LIM.
  localparam int RECIP_K      = 3435974;
  localparam int RECIP_SHIFT  = 35;
  localparam int NOTE_SAT_LIM = 1280000;

  localparam logic [6:0] NOTE_MAX = 7'd127;
  localparam logic [6:0] NOTE_MIN = 7'd0;

  // Shared multiplier operand width (signed).
  localparam int MUL_W = 25;

  // Frequency input and top bit of the normalized mantissa.
  localparam int FREQ_W  = 24;
  localparam int EXP_W   = 5;
  localparam logic [EXP_W-1:0] EXP_TOP = 5'd23;

  // Width of the signed pitch / offset accumulator.
  localparam int ACC_W = 24;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_LOG,
    ST_CENTS,
    ST_NOTE,
    ST_OFFSET,
    ST_UP,
    ST_DOWN,
    ST_EMIT
  } nth_state_t;

endpackage

/* rtl/note_tracker_with_hysteresis_core.sv */
// ----------------------------------------------------------------------------
// note_tracker_with_hysteresis_core: frequency to MIDI note with hysteresis
// Converts a Q16.8 Hz frequency into a held MIDI note and a cents offset,
// using one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input request channel (in_valid / in_stall) carries pitch_valid and
//   frequency_q8. A request is taken at a clock edge with in_valid high and
//   in_stall low; in_stall stays high from acceptance until the result has
//   been placed in the output register.
//   Output request channel (out_valid / out_stall) carries has_pitch,
//   midi_note, cents_hundredths and frequency_out. One result per input.
//   The output register is separate, so a new input is taken while the
//   previous result still waits on a stalled receiver.
//   hysteresis_we writes hysteresis_cents (whole cents) into the hysteresis register.
// Sequence: a request without pitch goes straight to the result register;
//   a pitch request is normalized by a one-bit-per-cycle shift until the
//   leading one reaches the top, then takes LOG_FRAC_BITS squaring passes
//   through the shared 25x25 multiplier, the cents step, a fresh-note pick
//   when no note is held, the offset step and a walk of the held note, one
//   semitone step per cycle, up and then down. A new request is taken only
//   after the result has been loaded, so requests do not overlap.
// Reset (rst, synchronous) drops any held note, sets hysteresis to 50 cents
//   and empties the output register. A stalled receiver holds the result;
//   a finished item then waits in its last state until the register frees.
// ----------------------------------------------------------------------------
module note_tracker_with_hysteresis_core #(
  parameter int LOG_FRAC_BITS = nth_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          hysteresis_we,
  input  logic [6:0]                    hysteresis_cents,
  // input requests
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          pitch_valid,
  input  logic [nth_pkg::FREQ_W-1:0]    frequency_q8,
  // result requests
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          has_pitch,
  output logic [6:0]                    midi_note,
  output logic signed [15:0]            cents_hundredths,
  output logic [nth_pkg::FREQ_W-1:0]    frequency_out
);

  localparam int F     = LOG_FRAC_BITS;
  localparam int LW    = nth_pkg::EXP_W + F;          // log2 value width
  localparam int CW    = $clog2(F);                   // squaring pass counter
  localparam int MW    = nth_pkg::MUL_W;
  localparam int PW    = 2 * MW;                      // product width
  localparam int AW    = nth_pkg::ACC_W;
  localparam int FW    = nth_pkg::FREQ_W;

  // log2(440 * 256) rounded half up to F fraction bits.
  localparam logic [63:0] REF_FULL =
    (nth_pkg::REF_LOG2_Q32 + (64'd1 << (31 - F))) >> (32 - F);
  localparam logic [LW-1:0] REF_LOG = REF_FULL[LW-1:0];

  localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (F - 1);

  localparam logic signed [AW-1:0] PITCH_A4  = AW'(nth_pkg::PITCH_A4);
  localparam logic signed [AW-1:0] NOTE_STEP = AW'(nth_pkg::NOTE_STEP);
  localparam logic signed [AW-1:0] HALF_STEP = AW'(nth_pkg::HALF_STEP);
  localparam logic signed [AW-1:0] SAT_LIM   = AW'(nth_pkg::NOTE_SAT_LIM);
  localparam logic signed [AW-1:0] OFF_HI    = AW'(nth_pkg::OFF_LIMIT);
  localparam logic signed [AW-1:0] OFF_LO    = -AW'(nth_pkg::OFF_LIMIT);

  nth_pkg::nth_state_t state, state_next;

  // configuration and tracker state
  logic [6:0]               hyst;
  logic                     note_held;
  logic [6:0]               held_note;

  // working registers
  logic [FW-1:0]            freq;
  logic                     pitch_ok;
  logic [FW-1:0]            mant;
  logic [nth_pkg::EXP_W-1:0] expo;
  logic [F-1:0]             frac;
  logic [CW-1:0]            cnt;
  logic signed [AW-1:0]     acc;

  // output register
  logic                     res_pitch;
  logic [6:0]               res_note;
  logic signed [15:0]       res_cents;
  logic [FW-1:0]            res_freq;

  // shared multiplier
  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [PW-1:0]     prod;

  // derived values
  logic [FW:0]              sq;
  logic signed [LW:0]       log_diff;
  logic signed [PW-1:0]     cents_shift;
  logic signed [AW-1:0]     near_x;
  logic signed [AW-1:0]     hyst_h;
  logic                     emit_go;

  assign prod = mul_a * mul_b;

  // squared mantissa, Q23 after the shift: value in [1, 4)
  assign sq = prod[FW+23:23];

  assign log_diff = $signed({1'b0, expo, frac}) - $signed({1'b0, REF_LOG});
  assign cents_shift = (prod + ROUND_HALF) >>> F;
  assign near_x = acc + HALF_STEP;
  assign hyst_h = AW'(hyst) * AW'(nth_pkg::HYST_SCALE);
  assign emit_go = !out_valid || !out_stall;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      nth_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (pitch_valid && frequency_q8 != '0) ? nth_pkg::ST_NORM
                                                           : nth_pkg::ST_EMIT;
        end
      end
      nth_pkg::ST_NORM: begin
        if (mant[FW-1]) state_next = nth_pkg::ST_LOG;
      end
      nth_pkg::ST_LOG: begin
        if (cnt == CW'(F - 1)) state_next = nth_pkg::ST_CENTS;
      end
      nth_pkg::ST_CENTS: begin
        state_next = note_held ? nth_pkg::ST_OFFSET : nth_pkg::ST_NOTE;
      end
      nth_pkg::ST_NOTE:   state_next = nth_pkg::ST_OFFSET;
      nth_pkg::ST_OFFSET: state_next = nth_pkg::ST_UP;
      nth_pkg::ST_UP: begin
        if (!(acc > hyst_h && held_note < nth_pkg::NOTE_MAX)) begin
          state_next = nth_pkg::ST_DOWN;
        end
      end
      nth_pkg::ST_DOWN: begin
        if (!(acc < -hyst_h && held_note > nth_pkg::NOTE_MIN)) begin
          state_next = nth_pkg::ST_EMIT;
        end
      end
      nth_pkg::ST_EMIT: begin
        if (emit_go) state_next = nth_pkg::ST_IDLE;
      end
      default: state_next = nth_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the sequencer: handshake and multiplier operand select
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall = (state != nth_pkg::ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      nth_pkg::ST_LOG: begin
        mul_a = MW'({1'b0, mant});
        mul_b = MW'({1'b0, mant});
      end
      nth_pkg::ST_CENTS: begin
        mul_a = MW'(log_diff);
        mul_b = MW'(nth_pkg::CENTS_PER_OCT);
      end
      nth_pkg::ST_NOTE: begin
        mul_a = MW'(near_x);
        mul_b = MW'(nth_pkg::RECIP_K);
      end
      nth_pkg::ST_OFFSET: begin
        mul_a = MW'({1'b0, held_note});
        mul_b = MW'(nth_pkg::NOTE_STEP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nth_pkg::ST_IDLE;
      hyst      <= nth_pkg::HYST_RESET;
      note_held <= 1'b0;
      held_note <= nth_pkg::NOTE_MIN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (hysteresis_we) hyst <= hysteresis_cents;

      unique case (state)
        nth_pkg::ST_IDLE: begin
          // drop the held note on a request without pitch
          if (in_valid && !(pitch_valid && frequency_q8 != '0)) begin
            note_held <= 1'b0;
          end
        end
        nth_pkg::ST_NOTE: begin
          note_held <= 1'b1;
          if (acc < 0) begin
            held_note <= nth_pkg::NOTE_MIN;
          end else if (near_x >= SAT_LIM) begin
            held_note <= nth_pkg::NOTE_MAX;
          end else begin
            held_note <= prod[nth_pkg::RECIP_SHIFT+6:nth_pkg::RECIP_SHIFT];
          end
        end
        nth_pkg::ST_UP: begin
          if (acc > hyst_h && held_note < nth_pkg::NOTE_MAX) begin
            held_note <= held_note + 7'd1;
          end
        end
        nth_pkg::ST_DOWN: begin
          if (acc < -hyst_h && held_note > nth_pkg::NOTE_MIN) begin
            held_note <= held_note - 7'd1;
          end
        end
        default: ;
      endcase

      // hold the result until the receiver takes it
      if (state == nth_pkg::ST_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      nth_pkg::ST_IDLE: begin
        freq     <= frequency_q8;
        mant     <= frequency_q8;
        pitch_ok <= pitch_valid && frequency_q8 != '0;
        expo     <= nth_pkg::EXP_TOP;
        frac     <= '0;
        cnt      <= '0;
      end
      nth_pkg::ST_NORM: begin
        // shift one bit a cycle until the leading one reaches the top
        if (!mant[FW-1]) begin
          mant <= mant << 1;
          expo <= expo - 1'b1;
        end
      end
      nth_pkg::ST_LOG: begin
        // square, then renormalize to [1, 2) and take one fraction bit
        cnt <= cnt + 1'b1;
        if (sq[FW]) begin
          mant <= sq[FW:1];
          frac <= {frac[F-2:0], 1'b1};
        end else begin
          mant <= sq[FW-1:0];
          frac <= {frac[F-2:0], 1'b0};
        end
      end
      nth_pkg::ST_CENTS: begin
        acc <= PITCH_A4 + cents_shift[AW-1:0];
      end
      nth_pkg::ST_OFFSET: begin
        acc <= acc - prod[AW-1:0];
      end
      nth_pkg::ST_UP: begin
        if (acc > hyst_h && held_note < nth_pkg::NOTE_MAX) acc <= acc - NOTE_STEP;
      end
      nth_pkg::ST_DOWN: begin
        if (acc < -hyst_h && held_note > nth_pkg::NOTE_MIN) acc <= acc + NOTE_STEP;
      end
      default: ;
    endcase

    if (state == nth_pkg::ST_EMIT && emit_go) begin
      res_pitch <= pitch_ok;
      if (pitch_ok) begin
        res_note <= held_note;
        res_freq <= freq;
        if (acc > OFF_HI) begin
          res_cents <= OFF_HI[15:0];
        end else if (acc < OFF_LO) begin
          res_cents <= OFF_LO[15:0];
        end else begin
          res_cents <= acc[15:0];
        end
      end else begin
        res_note  <= '0;
        res_freq  <= '0;
        res_cents <= '0;
      end
    end
  end

  assign has_pitch        = res_pitch;
  assign midi_note        = res_note;
  assign cents_hundredths = res_cents;
  assign frequency_out    = res_freq;

endmodule

/* bench/note_tracker_with_hysteresis_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_tracker_with_hysteresis_core_tb: self-checking bench for the note tracker
// Drives analysis requests (pitch flag plus Q16.8 frequency) through the
// valid/stall input channel and predicts each result with a bit-exact model
// of the fixed-point log, cents math, nearest-note pick and hysteresis walk.
// Results are checked in order as they leave the output channel. Both sides
// idle at random, the receiver holds off once for a long stretch, and the
// hysteresis register is swept between phases while the block is empty.
// ----------------------------------------------------------------------------
module note_tracker_with_hysteresis_core_tb;

  localparam int FREQ_W          = nth_pkg::FREQ_W;
  localparam int FRAC_BITS       = nth_pkg::LOG_FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int MAX_REPORTED    = 10;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 60;
  localparam int IDLE_PERCENT    = 24;
  localparam logic [FREQ_W-1:0] A4_Q8 = 24'd112640;

  // log2(440 Hz in Q8), rounded half up to the log fraction width.
  localparam longint A4_LOG =
    longint'((nth_pkg::REF_LOG2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

  typedef struct packed {
    logic                     has_pitch;
    logic [6:0]               midi_note;
    logic signed [15:0]       cents_hundredths;
    logic [FREQ_W-1:0]        frequency_out;
  } note_report_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     hysteresis_we;
  logic [6:0]               hysteresis_cents;
  logic                     in_valid;
  logic                     in_stall;
  logic                     pitch_valid;
  logic [FREQ_W-1:0]        frequency_q8;
  logic                     out_valid;
  logic                     out_stall;
  logic                     has_pitch;
  logic [6:0]               midi_note;
  logic signed [15:0]       cents_hundredths;
  logic [FREQ_W-1:0]        frequency_out;

  // Stimulus controls: steady turns off idling on both sides, hold_go asks
  // the receiver for its one long hold-off.
  logic steady;
  logic hold_go;
  bit   hold_taken;
  int   hold_left;

  // Tracker state as the block should hold it.
  logic       tracker_held;
  logic [6:0] tracker_note;
  logic [6:0] tracker_hyst;

  note_report_t expected_reports[$];
  int mismatches;
  int cycle_count;

  note_tracker_with_hysteresis_core #(
    .LOG_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .hysteresis_we(hysteresis_we),
    .hysteresis_cents(hysteresis_cents),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pitch_valid(pitch_valid),
    .frequency_q8(frequency_q8),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .has_pitch(has_pitch),
    .midi_note(midi_note),
    .cents_hundredths(cents_hundredths),
    .frequency_out(frequency_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Pitch math
  // --------------------------------------------------------------------------

  // Base-2 log of the Q8 frequency: integer part from the leading one, then
  // one fraction bit per squaring of the Q23 mantissa (truncating).
  function automatic longint pitch_log2(input logic [FREQ_W-1:0] freq);
    int                lead;
    int                i;
    longint unsigned   mant;
    longint            frac;
    lead = 0;
    while (lead < 23 && (freq >> (lead + 1)) != 0) lead++;
    mant = longint'(freq) << (23 - lead);
    frac = 0;
    for (i = 0; i < FRAC_BITS; i++) begin
      mant = (mant * mant) >> 23;
      frac = frac << 1;
      if (mant >= (64'd1 << 24)) begin
        frac = frac | 1;
        mant = mant >> 1;
      end
    end
    return (longint'(lead) << FRAC_BITS) | frac;
  endfunction

  // Absolute pitch in hundredths of a cent, A4 at 690000; the scaled log
  // difference is rounded half up with a floor shift.
  function automatic longint absolute_pitch(input logic [FREQ_W-1:0] freq);
    longint diff;
    diff = pitch_log2(freq) - A4_LOG;
    return nth_pkg::PITCH_A4 +
           ((diff * nth_pkg::CENTS_PER_OCT + (longint'(1) << (FRAC_BITS - 1)))
            >>> FRAC_BITS);
  endfunction

  // Advance the tracker by one request and return the result it reports.
  function automatic note_report_t track_note(input logic valid_in,
                                              input logic [FREQ_W-1:0] freq);
    note_report_t rep;
    longint       pitch;
    longint       band;
    longint       offset;
    longint       nearest;
    rep = '0;
    // No pitch: drop the held note but keep its number, report all zeros.
    if (!valid_in || freq == '0) begin
      tracker_held = 1'b0;
      return rep;
    end
    pitch = absolute_pitch(freq);
    // Fresh note: take the nearest one, clamped to the MIDI range.
    if (!tracker_held) begin
      nearest = (pitch >= 0) ? (pitch + nth_pkg::HALF_STEP) / nth_pkg::NOTE_STEP : 0;
      if (nearest > longint'(nth_pkg::NOTE_MAX)) nearest = longint'(nth_pkg::NOTE_MAX);
      tracker_note = 7'(nearest);
      tracker_held = 1'b1;
    end
    // Walk the held note up, then down, until the offset is inside the band.
    band   = longint'(tracker_hyst) * nth_pkg::HYST_SCALE;
    offset = pitch - longint'(tracker_note) * nth_pkg::NOTE_STEP;
    while (offset > band && tracker_note < nth_pkg::NOTE_MAX) begin
      tracker_note = tracker_note + 7'd1;
      offset -= nth_pkg::NOTE_STEP;
    end
    while (offset < -band && tracker_note > nth_pkg::NOTE_MIN) begin
      tracker_note = tracker_note - 7'd1;
      offset += nth_pkg::NOTE_STEP;
    end
    if (offset > nth_pkg::OFF_LIMIT) offset = nth_pkg::OFF_LIMIT;
    if (offset < -nth_pkg::OFF_LIMIT) offset = -nth_pkg::OFF_LIMIT;
    rep.has_pitch        = 1'b1;
    rep.midi_note        = tracker_note;
    rep.cents_hundredths = 16'(offset);
    rep.frequency_out    = freq;
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Q8 frequency for an absolute pitch in whole cents (A4 = 6900), clamped.
  function automatic logic [FREQ_W-1:0] freq_for_cents(input real cents);
    real hz_q8;
    hz_q8 = 112640.0 * (2.0 ** ((cents - 6900.0) / 1200.0));
    if (hz_q8 < 1.0) return 24'd1;
    if (hz_q8 > 16777215.0) return 24'hFFFFFF;
    return FREQ_W'($rtoi(hz_q8));
  endfunction

  // Unstructured frequency: full-width noise, log-spread values, musical
  // pitches and the odd zero.
  function automatic logic [FREQ_W-1:0] random_freq();
    logic [FREQ_W-1:0] raw;
    raw = FREQ_W'($urandom);
    case ($urandom_range(3))
      0:       return raw;
      1:       return raw >> $urandom_range(23);
      2:       return freq_for_cents(real'($urandom_range(13000)));
      default: return ($urandom_range(15) == 0) ? '0 : raw >> $urandom_range(8, 20);
    endcase
  endfunction

  // Hysteresis setting, with both extremes drawn often.
  function automatic logic [6:0] pick_hysteresis();
    case ($urandom_range(3))
      0:       return 7'd0;
      1:       return 7'd100;
      default: return 7'($urandom_range(100));
    endcase
  endfunction

  // Offer one request and wait for the handshake; predict its result once it
  // is taken. Valid stays high afterwards so back-to-back requests need no gap.
  task automatic offer_request(input logic valid_in, input logic [FREQ_W-1:0] freq);
    if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
    end
    in_valid     <= 1'b1;
    pitch_valid  <= valid_in;
    frequency_q8 <= freq;
    do @(posedge clk); while (in_stall);
    expected_reports.push_back(track_note(valid_in, freq));
  endtask

  // Drop valid and hold until every predicted result has come out.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  // Write the hysteresis register while the block is empty.
  task automatic set_hysteresis(input logic [6:0] cents);
    wait_for_drain();
    hysteresis_cents <= cents;
    hysteresis_we    <= 1'b1;
    @(posedge clk);
    hysteresis_we    <= 1'b0;
    tracker_hyst = cents;
  endtask

  // One musical phrase: a slow glide with small drift, occasional jumps,
  // dropouts and stray readings.
  task automatic play_glide(input int len);
    int  k;
    real cents;
    cents = ($urandom_range(19) == 0) ? real'($urandom_range(17000)) - 1000.0
                                      : real'($urandom_range(13500));
    for (k = 0; k < len; k++) begin
      if ($urandom_range(14) == 0) begin
        offer_request(1'b0, random_freq());
      end else if ($urandom_range(24) == 0) begin
        offer_request(1'b1, random_freq());
      end else begin
        if ($urandom_range(9) == 0) cents += real'($urandom_range(600)) - 300.0;
        else cents += (real'($urandom_range(800)) - 400.0) / 10.0;
        offer_request(1'b1, freq_for_cents(cents));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, no-pitch cases, note range ends, offset saturation and
  // both sides of the default 50-cent band.
  task automatic test_directed_cases();
    offer_request(1'b0, A4_Q8);                    // flag low, frequency ignored
    offer_request(1'b1, 24'd0);                    // zero frequency is no pitch
    offer_request(1'b1, A4_Q8);                    // A4 exactly
    offer_request(1'b1, freq_for_cents(6940.0));   // inside band: hold A4
    offer_request(1'b1, freq_for_cents(6960.0));   // outside band: step up
    offer_request(1'b1, freq_for_cents(6840.0));   // fall back down
    offer_request(1'b1, 24'd1);                    // walk down to note 0, clamp
    offer_request(1'b0, 24'd0);
    offer_request(1'b1, 24'd1);                    // fresh at the bottom
    offer_request(1'b1, 24'hFFFFFF);               // walk all the way up to 127
    offer_request(1'b0, 24'd5);
    offer_request(1'b1, 24'hFFFFFF);               // fresh at the top, clamp
    offer_request(1'b1, 24'h800000);
    offer_request(1'b1, 24'h000100);               // 1 Hz
    offer_request(1'b1, 24'h7FFFFF);
    offer_request(1'b0, 24'h555555);
    offer_request(1'b1, 24'hAAAAAA);
    offer_request(1'b1, 24'h555555);
    offer_request(1'b0, 24'hFFFFFF);
    offer_request(1'b1, freq_for_cents(6950.0));   // fresh, halfway between notes
    offer_request(1'b1, freq_for_cents(6949.0));
  endtask

  // Sweep the hysteresis register through 0 and 100 and back to reset value.
  task automatic test_hysteresis_extremes();
    set_hysteresis(7'd0);
    play_glide(14);
    set_hysteresis(7'd100);
    play_glide(14);
    set_hysteresis(7'd27);
    play_glide(12);
    set_hysteresis(7'($urandom_range(100)));
    play_glide(12);
    set_hysteresis(nth_pkg::HYST_RESET);
    play_glide(12);
  endtask

  // Unstructured requests: random flags and frequencies of every shape.
  task automatic test_random_noise(input int count);
    int k;
    for (k = 0; k < count; k++)
      offer_request($urandom_range(3) != 0, random_freq());
  endtask

  // Bulk of the run: phrases under changing hysteresis, with one long
  // stretch where neither side idles.
  task automatic test_glides(input int target);
    int sent;
    int len;
    int phrases;
    sent    = 0;
    phrases = 0;
    while (sent < target) begin
      if (phrases % 8 == 7) set_hysteresis(pick_hysteresis());
      steady <= (phrases >= 4 && phrases < 10);
      len = $urandom_range(10, 40);
      play_glide(len);
      sent += len;
      phrases++;
    end
    steady <= 1'b0;
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // block fills up and stalls its input.
  task automatic test_receiver_hold_off();
    hold_go <= 1'b1;
    play_glide(40);
  endtask

  // Sender pauses until everything is out, then resumes on a held note.
  task automatic test_drain_pause();
    play_glide(25);
    wait_for_drain();
    play_glide(25);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall, one long hold-off on request, none while steady
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare every accepted result with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    note_report_t want;
    note_report_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {has_pitch, midi_note, cents_hundredths, frequency_out};
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("unexpected result: pitch %0b note %0d cents %0d freq %0d",
                   got.has_pitch, got.midi_note, got.cents_hundredths,
                   got.frequency_out);
      end else begin
        want = expected_reports.pop_front();
        if (got.has_pitch !== want.has_pitch || got.midi_note !== want.midi_note ||
            got.cents_hundredths !== want.cents_hundredths ||
            got.frequency_out !== want.frequency_out) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display({"mismatch: expected pitch %0b note %0d cents %0d freq %0d,",
                      " got pitch %0b note %0d cents %0d freq %0d"},
                     want.has_pitch, want.midi_note, want.cents_hundredths,
                     want.frequency_out, got.has_pitch, got.midi_note,
                     got.cents_hundredths, got.frequency_out);
        end
      end
    end
  end

  // Watchdog: end the run if it goes far beyond the slowest correct case.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    mismatches       = 0;
    tracker_held     = 1'b0;
    tracker_note     = 7'd0;
    tracker_hyst     = nth_pkg::HYST_RESET;
    rst              <= 1'b1;
    hysteresis_we    <= 1'b0;
    hysteresis_cents <= nth_pkg::HYST_RESET;
    in_valid         <= 1'b0;
    pitch_valid      <= 1'b0;
    frequency_q8     <= '0;
    out_stall        <= 1'b0;
    steady           <= 1'b0;
    hold_go          <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_hysteresis_extremes();
    test_random_noise(250);
    test_glides(620);
    test_receiver_hold_off();
    test_drain_pause();

    // Let the last results out, then give the block a little more time.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* note_tracker_with_hysteresis_core.f */
rtl/nth_pkg.sv
rtl/note_tracker_with_hysteresis_core.sv
bench/note_tracker_with_hysteresis_core_tb.sv
